>>> hw/rtl/ntb_pkg.sv
`default_nettype none
package ntb_pkg;

  localparam int unsigned ENTRY_BITS = 9;
  localparam int unsigned FRAME_BITS = 40;
  localparam int unsigned LEAF_LSB   = 12;
  localparam int unsigned TOP_LSB    = 39;
  localparam logic [2:0]  TABLE_PERM = 3'd7;
  localparam logic [11:0] ROOT_ATTR  = 12'h01E;

  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_MAP     = 2'd1,
    ACT_DESTROY = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    INV_NONE   = 2'd0,
    INV_SINGLE = 2'd1,
    INV_ALL    = 2'd2
  } inv_t;

  typedef enum logic {
    REG_POOL_BASE = 1'b0,
    REG_SINGLE    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] guest_address;
    logic [51:0] host_address;
    logic [2:0]  perm_flags;
    logic [51:0] root_pointer;
  } ntb_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [51:0] new_root_pointer;
    logic [4:0]  pages_in_use;
    logic [1:0]  invalidate_kind;
  } ntb_out_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [2:0]            perm;
  } tbl_entry_t;

  typedef struct packed {
    logic set;
    logic clr;
  } pool_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/ntb_table_mem.sv
`default_nettype none
module ntb_table_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire ntb_pkg::tbl_entry_t wdata,
  input  wire logic [AW-1:0]       raddr,
  output ntb_pkg::tbl_entry_t      rdata
);

  ntb_pkg::tbl_entry_t mem [DEPTH];
  ntb_pkg::tbl_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

>>> hw/rtl/ntb_pool.sv
`default_nettype none
module ntb_pool #(
  parameter int unsigned POOL_PAGES = 16,
  parameter int unsigned PW         = 4,
  parameter int unsigned CW         = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ntb_pkg::pool_cmd_t cmd,
  input  wire logic [PW-1:0]      idx,
  output logic [POOL_PAGES-1:0]   used,
  output logic [CW-1:0]           count
);

  logic [POOL_PAGES-1:0] used_r, used_nxt;
  logic [CW-1:0]         count_r, count_nxt;

  always_comb begin
    used_nxt  = used_r;
    count_nxt = count_r;
    if (cmd.set) begin
      used_nxt[idx] = 1'b1;
      count_nxt     = count_r + CW'(1);
    end else if (cmd.clr && used_r[idx]) begin
      used_nxt[idx] = 1'b0;
      count_nxt     = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      count_r <= '0;
    end else begin
      used_r  <= used_nxt;
      count_r <= count_nxt;
    end
  end

  assign used  = used_r;
  assign count = count_r;

endmodule
`default_nettype wire

>>> hw/rtl/nested_page_table_builder.sv
// Nested page table builder: builds four-level extended page tables in a pool
// of POOL_PAGES table pages of 512 entries, held in one table memory.
// Input channel in_valid/in_stall/in_data carries one request: create a root,
// map a page, or destroy a tree. The output channel out_valid/out_stall/
// out_data returns exactly one result per request, in order.
// Requests are taken one at a time; in_stall is low only while no request is
// in progress. A finished result sits in an output register, so the next
// request is accepted while that result is still stalled.
// Each page allocation scans the pool bitmap one page a cycle and then clears
// the page one entry a cycle. A create allocates one page for the root; a map
// walks the levels from 3 down to 0 and allocates a new table for each level
// whose entry is missing.
// A destroy reads every entry of every upper-level table it reaches (levels
// 3..1), S_DRD reading and S_DEV evaluating each entry, and frees the pages.
// The table memory has one write and one read port with registered read data.
// Reset (rst_n low, synchronous) frees every page, sets the count to zero,
// pool_base to zero and single_invalidate_supported to one; no clearing pass
// is needed as pages are cleared when allocated.
// APB registers: pool_base at byte 0, single_invalidate_supported at byte 8.
// The user writes them only while no request is in progress; not enforced.
`default_nettype none
module nested_page_table_builder #(
  parameter int unsigned POOL_PAGES = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ntb_pkg::ntb_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ntb_pkg::ntb_out_t     out_data,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);

  localparam int unsigned PW    = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned CW    = $clog2(POOL_PAGES + 1);
  localparam int unsigned AW    = PW + ntb_pkg::ENTRY_BITS;
  localparam int unsigned DEPTH = POOL_PAGES * 512;
  localparam int unsigned FB    = ntb_pkg::FRAME_BITS;
  localparam int unsigned EB    = ntb_pkg::ENTRY_BITS;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ALLOC = 11'b00000000010,
    S_CLR   = 11'b00000000100,
    S_MCHK  = 11'b00000001000,
    S_MEV   = 11'b00000010000,
    S_MWR   = 11'b00000100000,
    S_DST   = 11'b00001000000,
    S_DRD   = 11'b00010000000,
    S_DEV   = 11'b00100000000,
    S_DFREE = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [51:0] base_r;
  logic        single_r;

  ntb_pkg::ntb_in_t req_r, req_nxt;
  logic [FB-1:0]    frame_r, frame_nxt;
  logic [1:0]       lvl_r, lvl_nxt;
  logic [PW-1:0]    cur_p_r, cur_p_nxt;
  logic [PW-1:0]    scan_r, scan_nxt;
  logic [EB-1:0]    clr_r, clr_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [51:0]      newroot_r, newroot_nxt;
  logic [1:0]       inv_r, inv_nxt;
  logic [PW-1:0]    dp_r [1:3];
  logic [PW-1:0]    dp_nxt [1:3];
  logic [EB-1:0]    di_r [1:3];
  logic [EB-1:0]    di_nxt [1:3];

  logic              out_valid_r;
  ntb_pkg::ntb_out_t out_r;

  ntb_pkg::pool_cmd_t  pcmd;
  logic [PW-1:0]       pidx;
  logic [POOL_PAGES-1:0] used;
  logic [CW-1:0]       count;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  ntb_pkg::tbl_entry_t mem_wdata, mem_rdata;

  logic          live_a, live_e, live_r;
  logic [PW-1:0] idx_a, idx_e, idx_r;
  logic          accept_in, out_free;

  function automatic logic [FB:0] page_of(input logic [FB-1:0] fr, input logic [51:0] base,
                                          input logic [POOL_PAGES-1:0] bm);
    logic [FB-1:0] off;
    logic          ok;
    off = fr - base[51:12];
    ok  = (off < FB'(POOL_PAGES));
    if (ok) begin
      ok = bm[off[PW-1:0]];
    end
    return {ok, off};
  endfunction

  function automatic logic [EB-1:0] level_index(input logic [47:0] ga, input logic [1:0] lvl);
    logic [EB-1:0] r;
    unique case (lvl)
      2'd3:    r = ga[47:39];
      2'd2:    r = ga[38:30];
      2'd1:    r = ga[29:21];
      default: r = ga[20:12];
    endcase
    return r;
  endfunction

  logic [FB:0] chk_a, chk_e, chk_r;
  assign chk_a  = page_of(frame_r, base_r, used);
  assign chk_e  = page_of(mem_rdata.frame, base_r, used);
  assign chk_r  = page_of(req_r.root_pointer[51:12], base_r, used);
  assign live_a = chk_a[FB];
  assign live_e = chk_e[FB];
  assign live_r = chk_r[FB];
  assign idx_a  = chk_a[PW-1:0];
  assign idx_e  = chk_e[PW-1:0];
  assign idx_r  = chk_r[PW-1:0];

  logic [FB-1:0] new_frame;
  assign new_frame = base_r[51:12] + FB'(scan_r);

  assign in_stall  = (state_r != S_IDLE);
  assign accept_in = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    frame_nxt   = frame_r;
    lvl_nxt     = lvl_r;
    cur_p_nxt   = cur_p_r;
    scan_nxt    = scan_r;
    clr_nxt     = clr_r;
    status_nxt  = status_r;
    newroot_nxt = newroot_r;
    inv_nxt     = inv_r;
    dp_nxt      = dp_r;
    di_nxt      = di_r;
    pcmd        = '0;
    pidx        = scan_r;
    mem_we      = 1'b0;
    mem_waddr   = {scan_r, clr_r};
    mem_wdata   = '0;
    mem_raddr   = {idx_a, level_index(req_r.guest_address, lvl_r)};

    unique case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          req_nxt     = in_data;
          frame_nxt   = in_data.root_pointer[51:12];
          lvl_nxt     = 2'd3;
          scan_nxt    = '0;
          status_nxt  = ntb_pkg::ST_OK;
          newroot_nxt = '0;
          inv_nxt     = ntb_pkg::INV_NONE;
          unique case (ntb_pkg::action_t'(in_data.action))
            ntb_pkg::ACT_CREATE:  state_nxt = S_ALLOC;
            ntb_pkg::ACT_MAP:     state_nxt = S_MCHK;
            ntb_pkg::ACT_DESTROY: state_nxt = S_DST;
            ntb_pkg::ACT_NONE:    state_nxt = S_DONE;
          endcase
        end
      end
      S_ALLOC: begin
        if (!used[scan_r]) begin
          pcmd.set  = 1'b1;
          clr_nxt   = '0;
          state_nxt = S_CLR;
        end else if (scan_r == PW'(POOL_PAGES - 1)) begin
          status_nxt = ntb_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          scan_nxt = scan_r + PW'(1);
        end
      end
      S_CLR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + EB'(1);
        if (clr_r == '1) begin
          if (req_r.action == ntb_pkg::ACT_CREATE) begin
            newroot_nxt = {new_frame, ntb_pkg::ROOT_ATTR};
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_MWR;
          end
        end
      end
      S_MCHK: begin
        cur_p_nxt = idx_a;
        if (!live_a) begin
          status_nxt = ntb_pkg::ST_INVALID;
          state_nxt  = S_DONE;
        end else if (lvl_r == 2'd0) begin
          if (req_r.perm_flags == 3'd0) begin
            status_nxt = ntb_pkg::ST_INVALID;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = {idx_a, level_index(req_r.guest_address, lvl_r)};
            mem_wdata = {req_r.host_address[51:12], req_r.perm_flags};
          end
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MEV;
        end
      end
      S_MEV: begin
        if (mem_rdata.perm != 3'd0) begin
          frame_nxt = mem_rdata.frame;
          lvl_nxt   = lvl_r - 2'd1;
          state_nxt = S_MCHK;
        end else begin
          scan_nxt  = '0;
          state_nxt = S_ALLOC;
        end
      end
      S_MWR: begin
        mem_we    = 1'b1;
        mem_waddr = {cur_p_r, level_index(req_r.guest_address, lvl_r)};
        mem_wdata = {new_frame, ntb_pkg::TABLE_PERM};
        frame_nxt = new_frame;
        lvl_nxt   = lvl_r - 2'd1;
        state_nxt = S_MCHK;
      end
      S_DST: begin
        if (req_r.root_pointer[51:12] == '0) begin
          state_nxt = S_DONE;
        end else begin
          inv_nxt = single_r ? ntb_pkg::INV_SINGLE : ntb_pkg::INV_ALL;
          if (live_r) begin
            dp_nxt[3] = idx_r;
            di_nxt[3] = '0;
            lvl_nxt   = 2'd3;
            state_nxt = S_DRD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DRD: begin
        mem_raddr = {dp_r[lvl_r], di_r[lvl_r]};
        state_nxt = S_DEV;
      end
      S_DEV: begin
        if ((mem_rdata.perm != 3'd0) && live_e && (lvl_r != 2'd1)) begin
          dp_nxt[lvl_r - 2'd1] = idx_e;
          di_nxt[lvl_r - 2'd1] = '0;
          lvl_nxt              = lvl_r - 2'd1;
          state_nxt            = S_DRD;
        end else begin
          if ((mem_rdata.perm != 3'd0) && live_e) begin
            pcmd.clr = 1'b1;
            pidx     = idx_e;
          end
          if (di_r[lvl_r] == '1) begin
            state_nxt = S_DFREE;
          end else begin
            di_nxt[lvl_r] = di_r[lvl_r] + EB'(1);
            state_nxt     = S_DRD;
          end
        end
      end
      S_DFREE: begin
        pcmd.clr = 1'b1;
        pidx     = dp_r[lvl_r];
        if (lvl_r == 2'd3) begin
          state_nxt = S_DONE;
        end else begin
          lvl_nxt = lvl_r + 2'd1;
          if (di_r[lvl_r + 2'd1] == '1) begin
            state_nxt = S_DFREE;
          end else begin
            di_nxt[lvl_r + 2'd1] = di_r[lvl_r + 2'd1] + EB'(1);
            state_nxt            = S_DRD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      single_r    <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (psel && penable && pwrite) begin
        unique case (ntb_pkg::reg_idx_t'(paddr[3]))
          ntb_pkg::REG_POOL_BASE: base_r   <= pwdata[51:0];
          ntb_pkg::REG_SINGLE:    single_r <= pwdata[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    frame_r   <= frame_nxt;
    lvl_r     <= lvl_nxt;
    cur_p_r   <= cur_p_nxt;
    scan_r    <= scan_nxt;
    clr_r     <= clr_nxt;
    status_r  <= status_nxt;
    newroot_r <= newroot_nxt;
    inv_r     <= inv_nxt;
    dp_r      <= dp_nxt;
    di_r      <= di_nxt;
    if (state_r == S_DONE && out_free) begin
      out_r.status           <= status_r;
      out_r.new_root_pointer <= newroot_r;
      out_r.pages_in_use     <= 5'(count);
      out_r.invalidate_kind  <= inv_r;
    end
  end

  always_comb begin
    unique case (ntb_pkg::reg_idx_t'(paddr[3]))
      ntb_pkg::REG_POOL_BASE: prdata = {12'd0, base_r};
      ntb_pkg::REG_SINGLE:    prdata = {63'd0, single_r};
    endcase
  end

  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ntb_pool #(
    .POOL_PAGES(POOL_PAGES),
    .PW        (PW),
    .CW        (CW)
  ) u_pool (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (pcmd),
    .idx  (pidx),
    .used (used),
    .count(count)
  );

  ntb_table_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

endmodule
`default_nettype wire

>>> test/ntb_result_checker.sv
module ntb_result_checker
  import ntb_pkg::*;
#(
  parameter int unsigned POOL_PAGES = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire ntb_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire ntb_out_t out_data,
  input  wire logic     psel,
  input  wire logic     penable,
  input  wire logic     pwrite,
  input  wire logic     pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output int            errors,
  output int            pending
);

  localparam logic [51:0] FRAME_MASK = 52'hffffffffff000;

  logic [51:0] pool_base;
  bit          single_ok;
  bit          page_used [POOL_PAGES];
  int unsigned used_count;
  logic [51:0] entries [POOL_PAGES*512];
  ntb_out_t    due_results [$];

  function automatic logic [51:0] page_addr(int n);
    return (pool_base & FRAME_MASK) + (52'(n) << 12);
  endfunction

  function automatic bit live_page(logic [51:0] a, output int idx);
    logic [51:0] off;
    off = (a & FRAME_MASK) - (pool_base & FRAME_MASK);
    idx = int'(off >> 12);
    if ((off >> 12) >= POOL_PAGES) return 0;
    return page_used[idx];
  endfunction

  function automatic int grab_page();
    for (int n = 0; n < POOL_PAGES; n++) begin
      if (!page_used[n]) begin
        page_used[n] = 1;
        used_count++;
        for (int i = 0; i < 512; i++) entries[n*512+i] = '0;
        return n;
      end
    end
    return -1;
  endfunction

  function automatic void release_tree(logic [51:0] a, int lvl);
    int p;
    logic [51:0] e;
    if (!live_page(a, p)) return;
    if (lvl > 0) begin
      for (int i = 0; i < 512; i++) begin
        e = entries[p*512+i];
        if (e[2:0] != 0) release_tree(e & FRAME_MASK, lvl - 1);
      end
    end
    if (page_used[p]) begin
      page_used[p] = 0;
      if (used_count != 0) used_count--;
    end
  endfunction

  function automatic status_t map_walk(ntb_in_t r);
    logic [51:0] a;
    logic [51:0] e;
    int p;
    int n;
    int idx;
    a = r.root_pointer & FRAME_MASK;
    for (int sh = 39; sh > 12; sh -= 9) begin
      idx = int'((r.guest_address >> sh) & 48'h1ff);
      if (!live_page(a, p)) return ST_INVALID;
      e = entries[p*512+idx];
      if (e[2:0] == 0) begin
        n = grab_page();
        if (n < 0) return ST_FULL;
        e = page_addr(n) | 52'(TABLE_PERM);
        entries[p*512+idx] = e;
      end
      a = e & FRAME_MASK;
    end
    if (!live_page(a, p)) return ST_INVALID;
    if (r.perm_flags == 0) return ST_INVALID;
    entries[p*512+int'(r.guest_address[20:12])] =
      (r.host_address & FRAME_MASK) | 52'(r.perm_flags);
    return ST_OK;
  endfunction

  function automatic ntb_out_t build_result(ntb_in_t r);
    ntb_out_t o;
    int n;
    o = '0;
    case (action_t'(r.action))
      ACT_CREATE: begin
        n = grab_page();
        if (n < 0) o.status = ST_FULL;
        else o.new_root_pointer = page_addr(n) | 52'(ROOT_ATTR);
      end
      ACT_MAP: o.status = map_walk(r);
      ACT_DESTROY: begin
        if ((r.root_pointer & FRAME_MASK) != 0) begin
          o.invalidate_kind = single_ok ? INV_SINGLE : INV_ALL;
          release_tree(r.root_pointer & FRAME_MASK, 3);
        end
      end
      default: ;
    endcase
    o.pages_in_use = used_count[4:0];
    return o;
  endfunction

  assign pending = due_results.size();

  initial errors = 0;

  always @(posedge clk) begin
    ntb_out_t want;
    if (!rst_n) begin
      pool_base = '0;
      single_ok = 1;
      used_count = 0;
      for (int n = 0; n < POOL_PAGES; n++) page_used[n] = 0;
      due_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_POOL_BASE, 3'b000}) pool_base = pwdata[51:0];
        else if (paddr == {REG_SINGLE, 3'b000}) single_ok = pwdata[0];
      end
      if (in_valid && !in_stall) due_results.push_back(build_result(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $realtime, out_data);
        end else begin
          want = due_results.pop_front();
          if (want.status != out_data.status) begin
            errors++;
            $display("%0t: status expected %0d got %0d", $realtime, want.status,
                     out_data.status);
          end
          if (want.new_root_pointer != out_data.new_root_pointer) begin
            errors++;
            $display("%0t: new_root_pointer expected %h got %h", $realtime,
                     want.new_root_pointer, out_data.new_root_pointer);
          end
          if (want.pages_in_use != out_data.pages_in_use) begin
            errors++;
            $display("%0t: pages_in_use expected %0d got %0d", $realtime,
                     want.pages_in_use, out_data.pages_in_use);
          end
          if (want.invalidate_kind != out_data.invalidate_kind) begin
            errors++;
            $display("%0t: invalidate_kind expected %0d got %0d", $realtime,
                     want.invalidate_kind, out_data.invalidate_kind);
          end
        end
      end
    end
  end

endmodule

>>> test/nested_page_table_builder_test.sv
module nested_page_table_builder_test;
  import ntb_pkg::*;

  localparam logic [51:0] FRAME_MASK = 52'hffffffffff000;
  localparam int IDLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ntb_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ntb_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_left = 0;
  bit          hold_req = 0;
  int          quiet = 0;
  logic [51:0] cur_base = '0;

  nested_page_table_builder uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ntb_result_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 2000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic ntb_in_t mk(action_t a, logic [47:0] ga, logic [51:0] ha,
                                 logic [2:0] fl, logic [51:0] rp);
    ntb_in_t r;
    r.action = a;
    r.guest_address = ga;
    r.host_address = ha;
    r.perm_flags = fl;
    r.root_pointer = rp;
    return r;
  endfunction

  function automatic logic [51:0] page_ptr(int k);
    return (cur_base & FRAME_MASK) + (52'(k) << 12);
  endfunction

  function automatic logic [8:0] pick_index();
    int u;
    u = $urandom_range(99);
    if (u < 50) return 9'd0;
    if (u < 70) return 9'h1ff;
    if (u < 85) return 9'd1;
    return 9'($urandom);
  endfunction

  function automatic ntb_in_t random_request();
    ntb_in_t r;
    logic [63:0] w;
    int u;
    w = rand64();
    r = mk(ACT_MAP, w[47:0], 52'(rand64()), 3'($urandom), 52'(rand64()));
    if ($urandom_range(99) < 8) begin
      r.action = 2'($urandom);
      return r;
    end
    u = $urandom_range(99);
    if (u < 8) r.action = ACT_CREATE;
    else if (u < 93) r.action = ACT_MAP;
    else if (u < 97) r.action = ACT_DESTROY;
    else r.action = ACT_NONE;
    r.root_pointer = page_ptr($urandom_range(0, 17)) | 52'($urandom_range(0, 4095));
    r.guest_address = {pick_index(), pick_index(), pick_index(), pick_index(),
                       12'($urandom)};
    if ($urandom_range(99) < 90 && r.perm_flags == 0) r.perm_flags = 3'd7;
    return r;
  endfunction

  task automatic send_req(input ntb_in_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [51:0] bases [5];
    bit          singles [5];
    int          idles [5];
    int          stalls [5];
    bases = '{52'h0, 52'hffffffffff000, 52'h0, 52'h0, 52'h0};
    singles = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    idles = '{0, 87, 0, 23, 0};
    stalls = '{0, 0, 87, 23, 0};
    bases[2] = 52'(rand64());
    bases[3] = 52'hfffffffff8000;
    singles[4] = 1'($urandom);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_req(mk(ACT_NONE, '1, '1, '1, '1));
    send_req(mk(ACT_DESTROY, '1, '1, '1, 52'hfff));
    send_req(mk(ACT_CREATE, '0, '0, '0, '0));
    send_req(mk(ACT_MAP, '1, '1, 3'd7, page_ptr(0) | 52'h01e));
    send_req(mk(ACT_MAP, '0, '0, 3'd1, page_ptr(0)));
    send_req(mk(ACT_MAP, '0, 52'h123456789a000, 3'd0, page_ptr(0)));
    send_req(mk(ACT_MAP, 48'h1000, '1, 3'd6, page_ptr(9)));
    send_req(mk(ACT_MAP, 48'h1000, '1, 3'd2, 52'habcde12345000));
    send_req(mk(ACT_DESTROY, '0, '0, '0, page_ptr(15)));
    send_req(mk(ACT_DESTROY, '0, '0, '0, page_ptr(0) | 52'h01e));
    send_req(mk(ACT_CREATE, '1, '1, '1, '1));
    send_req(mk(ACT_MAP, 48'h8040201000, 52'h5a5a5a5a5a000, 3'd4, page_ptr(0)));
    for (int i = 0; i < 13; i++) send_req(mk(ACT_CREATE, '0, '0, '0, '0));
    send_req(mk(ACT_MAP, 48'hff7fbfdff000, '1, 3'd3, page_ptr(0)));
    send_req(mk(ACT_DESTROY, '0, '0, '0, page_ptr(0)));

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      cur_base = bases[ph];
      cfg_write(REG_POOL_BASE, {12'h0, bases[ph]});
      cfg_write(REG_SINGLE, {63'h0, singles[ph]});
      send_idle = idles[ph];
      recv_stall = stalls[ph];
      for (int i = 0; i < 200; i++) begin
        if (ph == 0 && i == 100) begin
          @(posedge clk);
          hold_req = 1;
          @(negedge clk);
          for (int j = 0; j < 8; j++) send_req(mk(ACT_NONE, '0, '0, '0, '0));
        end
        if (ph == 2 && i == 100) drain();
        send_req(random_request());
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
